// File: hw/rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the cursor shake detector.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int THR_W      = 12;
    localparam int SQ_W       = 2 * THR_W;
    localparam int REV_W      = 6;
    localparam int MINS_W     = 7;
    localparam int SIZE_W     = 8;

    localparam logic [REV_W-1:0] REV_MAX = 6'd63;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REVERSALS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SIZE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_SIZE     = 3'd6;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // verdict of the step unit for one pair of samples
    typedef struct packed {
        logic valid;
        logic counts;
        logic pos;
        logic neg;
    } step_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/csd_ram.sv
// ----------------------------------------------------------------------------
// csd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csd_step_unit.sv
// ----------------------------------------------------------------------------
// csd_step_unit
// Three-stage step evaluator: difference and magnitude test, squaring,
// squared-length compare. Takes one pair of samples per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_step_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] a_x,
    input  wire logic signed [COORD_WIDTH-1:0] a_y,
    input  wire logic signed [COORD_WIDTH-1:0] b_x,
    input  wire logic signed [COORD_WIDTH-1:0] b_y,
    input  wire logic [csd_pkg::THR_W-1:0]     threshold,
    output csd_pkg::step_res_t                 res,
    output logic                               busy
);

    import csd_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int CMPW = (CW + 1 > THR_W) ? CW + 1 : THR_W;

    logic [CW:0]   dx;
    logic [CW:0]   dy;
    logic [CW:0]   ax;
    logic [CW:0]   ay;
    logic [CMPW-1:0] ax_w;
    logic [CMPW-1:0] ay_w;
    logic [CMPW-1:0] thr_w;
    logic [SQ_W:0] sq_sum;

    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic            s1_big_reg, s2_big_reg;
    logic            s1_pos_reg, s2_pos_reg, s3_pos_reg;
    logic            s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [THR_W-1:0] s1_ax_reg, s1_ay_reg;
    logic [SQ_W-1:0] s2_sqx_reg, s2_sqy_reg;
    logic [SQ_W-1:0] thr_sq_reg;
    logic            s3_counts_reg;

    // one bit of headroom so the difference never overflows
    assign dx    = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
    assign dy    = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
    assign ax    = dx[CW] ? (~dx + 1'b1) : dx;
    assign ay    = dy[CW] ? (~dy + 1'b1) : dy;
    assign ax_w  = CMPW'(ax);
    assign ay_w  = CMPW'(ay);
    assign thr_w = CMPW'(threshold);

    assign sq_sum = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end

        thr_sq_reg <= threshold * threshold;

        // squares are only needed when both components are within threshold,
        // so the low bits suffice
        s1_big_reg <= (ax_w > thr_w) || (ay_w > thr_w);
        s1_ax_reg  <= ax_w[THR_W-1:0];
        s1_ay_reg  <= ay_w[THR_W-1:0];
        s1_pos_reg <= !dx[CW] && (dx != '0);
        s1_neg_reg <= dx[CW];

        s2_big_reg <= s1_big_reg;
        s2_sqx_reg <= s1_ax_reg * s1_ax_reg;
        s2_sqy_reg <= s1_ay_reg * s1_ay_reg;
        s2_pos_reg <= s1_pos_reg;
        s2_neg_reg <= s1_neg_reg;

        s3_counts_reg <= s2_big_reg || (sq_sum > {1'b0, thr_sq_reg});
        s3_pos_reg    <= s2_pos_reg;
        s3_neg_reg    <= s2_neg_reg;
    end

    assign res.valid  = s3_valid_reg;
    assign res.counts = s3_counts_reg;
    assign res.pos    = s3_pos_reg;
    assign res.neg    = s3_neg_reg;
    assign busy       = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cursor_shake_detector_top.sv
// ----------------------------------------------------------------------------
// cursor_shake_detector_top
// Millisecond clock, history ring in RAM and a sequencer that prunes old
// samples and walks the history through the shared step unit.
// ----------------------------------------------------------------------------
// Tick item: result loaded in ST_FINISH once the output register is free.
// Move item: stored, pruned and, when analysed, walked; paced by the single
// RAM read port (one history entry per cycle) and the 3-stage step unit.
// One item at a time; the next is taken the cycle after the result is loaded.
// Reset at once clears clock, ring pointers, zoom state and loads config defaults;
// the history RAM is not cleared, and unwritten entries never affect a result.
`default_nettype none

module cursor_shake_detector_top #(
    parameter int HISTORY_DEPTH = 64,
    parameter int COORD_WIDTH   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_opcode,
    input  wire logic signed [COORD_WIDTH-1:0]    s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]    s_pos_y,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_zoomed,
    output logic [csd_pkg::SIZE_W-1:0]            m_cursor_size,
    output logic                                  m_size_changed,
    output logic                                  m_shake_detected,
    output logic [csd_pkg::REV_W-1:0]             m_reversals,
    input  wire logic                             cfg_we,
    input  wire logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import csd_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int AW      = $clog2(HISTORY_DEPTH);
    localparam int FW      = $clog2(HISTORY_DEPTH + 1);
    localparam int CNTW    = (FW > MINS_W) ? FW : MINS_W;
    localparam int ENTRY_W = 2 * CW + TIME_W;
    localparam logic [AW:0]   DEPTH_V = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_V = FW'(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_PR_RD,
        ST_PR_CHK,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic [MS_W-1:0]   window_ms_reg;
    logic [THR_W-1:0]  step_threshold_reg;
    logic [REV_W-1:0]  min_reversals_reg;
    logic [MINS_W-1:0] min_samples_reg;
    logic [MS_W-1:0]   hold_ms_reg;
    logic [SIZE_W-1:0] normal_size_reg;
    logic [SIZE_W-1:0] large_size_reg;

    // block state
    logic [TIME_W-1:0] clock_reg;
    logic [AW-1:0]     oldest_reg;
    logic [FW-1:0]     fill_reg;
    logic              zoom_reg;
    logic [MS_W-1:0]   hold_reg;

    // per-item working registers
    logic              op_reg;
    logic [CW-1:0]     in_x_reg, in_y_reg;
    logic              changed_reg;
    logic              analysed_reg;
    logic [REV_W-1:0]  revs_reg;
    logic              last_pos_reg, last_neg_reg;
    logic [AW-1:0]     walk_k_reg;
    logic              rd_vld_reg, first_reg;
    logic [CW-1:0]     prev_x_reg, prev_y_reg;

    // output register
    logic              m_valid_reg;
    logic              m_zoomed_reg;
    logic [SIZE_W-1:0] m_size_reg;
    logic              m_changed_reg;
    logic              m_shake_reg;
    logic [REV_W-1:0]  m_revs_reg;

    // ring addressing
    logic              full;
    logic [AW-1:0]     oldest_inc;
    logic [AW-1:0]     oldest_wr;
    logic [FW-1:0]     fill_wr;
    logic [AW-1:0]     slot_k;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     slot;

    // RAM
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0]     rd_x, rd_y;
    logic [TIME_W-1:0] rd_time;
    logic [TIME_W-1:0] age;

    // step unit
    step_res_t         step_res;
    logic              step_busy;
    logic              step_in_valid;
    logic              rev_hit;

    // finish
    logic              out_free;
    logic              fin_shake, fin_zoom, fin_changed;
    logic              walk_last;

    assign full       = (fill_reg == FULL_V);
    assign oldest_inc = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + 1'b1;
    assign oldest_wr  = full ? oldest_inc : oldest_reg;
    assign fill_wr    = full ? fill_reg - 1'b1 : fill_reg;

    always_comb begin
        slot_k   = (state_reg == ST_WR) ? fill_wr[AW-1:0] : walk_k_reg;
        slot_sum = {1'b0, oldest_wr} + {1'b0, slot_k};
        if (state_reg != ST_WR) begin
            slot_sum = {1'b0, oldest_reg} + {1'b0, slot_k};
        end
        if (slot_sum >= DEPTH_V) begin
            slot_sum = slot_sum - DEPTH_V;
        end
        slot = slot_sum[AW-1:0];
    end

    assign ram_we    = (state_reg == ST_WR);
    assign ram_wdata = {in_x_reg, in_y_reg, clock_reg};
    assign ram_re    = (state_reg == ST_PR_RD) || (state_reg == ST_WALK);
    assign ram_raddr = (state_reg == ST_PR_RD) ? oldest_reg : slot;
    assign rd_x      = ram_rdata[ENTRY_W-1 -: CW];
    assign rd_y      = ram_rdata[TIME_W +: CW];
    assign rd_time   = ram_rdata[TIME_W-1:0];
    assign age       = clock_reg - rd_time;

    csd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign step_in_valid = rd_vld_reg && !first_reg;

    csd_step_unit #(
        .COORD_WIDTH (CW)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step_in_valid),
        .a_x       (prev_x_reg),
        .a_y       (prev_y_reg),
        .b_x       (rd_x),
        .b_y       (rd_y),
        .threshold (step_threshold_reg),
        .res       (step_res),
        .busy      (step_busy)
    );

    // a reversal needs two counted steps of opposite x sign
    assign rev_hit = (step_res.pos && last_neg_reg) || (step_res.neg && last_pos_reg);

    assign walk_last = (FW'(walk_k_reg) == fill_reg - 1'b1);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        fin_shake   = 1'b0;
        fin_zoom    = zoom_reg;
        fin_changed = changed_reg;
        if (op_reg == OP_MOVE) begin
            fin_shake = analysed_reg && (revs_reg >= min_reversals_reg);
            if (fin_shake && !zoom_reg) begin
                fin_zoom    = 1'b1;
                fin_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            window_ms_reg      <= 16'd500;
            step_threshold_reg <= 12'd10;
            min_reversals_reg  <= 6'd4;
            min_samples_reg    <= 7'd5;
            hold_ms_reg        <= 16'd2000;
            normal_size_reg    <= 8'd24;
            large_size_reg     <= 8'd64;
            clock_reg          <= '0;
            oldest_reg         <= '0;
            fill_reg           <= '0;
            zoom_reg           <= 1'b0;
            hold_reg           <= '0;
            rd_vld_reg         <= 1'b0;
            first_reg          <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WINDOW_MS:      window_ms_reg      <= cfg_data;
                    CFG_STEP_THRESHOLD: step_threshold_reg <= cfg_data[THR_W-1:0];
                    CFG_MIN_REVERSALS:  min_reversals_reg  <= cfg_data[REV_W-1:0];
                    CFG_MIN_SAMPLES:    min_samples_reg    <= cfg_data[MINS_W-1:0];
                    CFG_HOLD_MS:        hold_ms_reg        <= cfg_data;
                    CFG_NORMAL_SIZE:    normal_size_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_LARGE_SIZE:     large_size_reg     <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // in ST_FINISH the output register is reloaded below instead
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            rd_vld_reg <= (state_reg == ST_WALK);
            first_reg  <= (state_reg == ST_WALK) && (walk_k_reg == '0);
            if (rd_vld_reg) begin
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
            end

            if (step_res.valid && step_res.counts) begin
                if (rev_hit && (revs_reg != REV_MAX)) begin
                    revs_reg <= revs_reg + 1'b1;
                end
                last_pos_reg <= step_res.pos;
                last_neg_reg <= step_res.neg;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= s_opcode;
                        in_x_reg     <= s_pos_x;
                        in_y_reg     <= s_pos_y;
                        changed_reg  <= 1'b0;
                        analysed_reg <= 1'b0;
                        revs_reg     <= '0;
                        if (s_opcode == OP_TICK) begin
                            clock_reg <= clock_reg + 1'b1;
                            if (zoom_reg && (hold_reg != '0)) begin
                                hold_reg <= hold_reg - 1'b1;
                                if (hold_reg == MS_W'(1)) begin
                                    zoom_reg    <= 1'b0;
                                    changed_reg <= 1'b1;
                                end
                            end
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_WR;
                        end
                    end
                end
                ST_WR: begin
                    // full ring drops its oldest entry before the store
                    oldest_reg <= oldest_wr;
                    fill_reg   <= fill_wr + 1'b1;
                    state_reg  <= ST_PR_RD;
                end
                ST_PR_RD: begin
                    state_reg <= ST_PR_CHK;
                end
                ST_PR_CHK: begin
                    if ((fill_reg != '0) && (age > TIME_W'(window_ms_reg))) begin
                        oldest_reg <= oldest_inc;
                        fill_reg   <= fill_reg - 1'b1;
                        state_reg  <= ST_PR_RD;
                    end else if (CNTW'(fill_reg) >= CNTW'(min_samples_reg)) begin
                        analysed_reg <= 1'b1;
                        walk_k_reg   <= '0;
                        last_pos_reg <= 1'b0;
                        last_neg_reg <= 1'b0;
                        state_reg    <= ST_WALK;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_WALK: begin
                    if (walk_last) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        walk_k_reg <= walk_k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_vld_reg && !step_busy) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        if ((op_reg == OP_MOVE) && fin_shake && !zoom_reg) begin
                            hold_reg <= (hold_ms_reg != '0) ? hold_ms_reg : MS_W'(1);
                        end
                        zoom_reg      <= fin_zoom;
                        m_valid_reg   <= 1'b1;
                        m_zoomed_reg  <= fin_zoom;
                        m_size_reg    <= fin_zoom ? large_size_reg : normal_size_reg;
                        m_changed_reg <= fin_changed;
                        m_shake_reg   <= fin_shake;
                        m_revs_reg    <= revs_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_zoomed         = m_zoomed_reg;
    assign m_cursor_size    = m_size_reg;
    assign m_size_changed   = m_changed_reg;
    assign m_shake_detected = m_shake_reg;
    assign m_reversals      = m_revs_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_V)
        else $error("history fill beyond ring depth");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> fill_reg != '0)
        else $error("history walk over an empty ring");

    a_step_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        step_res.valid |-> (state_reg == ST_WALK) || (state_reg == ST_DRAIN))
        else $error("step verdict outside the history walk");

    a_shake_zooms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_shake_detected |-> m_zoomed)
        else $error("shake reported without large cursor");

    a_tick_no_revs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && (op_reg == OP_TICK) |-> revs_reg == '0)
        else $error("reversals counted on a tick item");
`endif

endmodule

`default_nettype wire

// File: tb/sv/cursor_shake_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_shake_checker
// Watches the item, result and register ports of the shake detector, keeps
// its own clock, history ring and zoom state, and checks every result field
// by field against the prediction for the oldest outstanding item.
// ----------------------------------------------------------------------------
module cursor_shake_checker
    import csd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_zoomed,
    input  logic [SIZE_W-1:0]             m_cursor_size,
    input  logic                          m_size_changed,
    input  logic                          m_shake_detected,
    input  logic [REV_W-1:0]              m_reversals,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic              zoomed;
        logic [SIZE_W-1:0] cursor_size;
        logic              size_changed;
        logic              shake_detected;
        logic [REV_W-1:0]  reversals;
    } cursor_report_t;

    localparam logic [MS_W-1:0]   WINDOW_RST      = 16'd500;
    localparam logic [THR_W-1:0]  THRESHOLD_RST   = 12'd10;
    localparam logic [REV_W-1:0]  MIN_REV_RST     = 6'd4;
    localparam logic [MINS_W-1:0] MIN_SAMPLES_RST = 7'd5;
    localparam logic [MS_W-1:0]   HOLD_RST        = 16'd2000;
    localparam logic [SIZE_W-1:0] NORMAL_RST      = 8'd24;
    localparam logic [SIZE_W-1:0] LARGE_RST       = 8'd64;

    // register copy
    logic [MS_W-1:0]   window_ms;
    logic [THR_W-1:0]  step_thr;
    logic [REV_W-1:0]  min_reversals;
    logic [MINS_W-1:0] min_samples;
    logic [MS_W-1:0]   hold_ms;
    logic [SIZE_W-1:0] normal_size;
    logic [SIZE_W-1:0] large_size;

    // detector state
    logic [TIME_W-1:0]             ms_clock;
    logic signed [COORD_WIDTH-1:0] hist_x [HISTORY_DEPTH];
    logic signed [COORD_WIDTH-1:0] hist_y [HISTORY_DEPTH];
    logic [TIME_W-1:0]             hist_t [HISTORY_DEPTH];
    int                            oldest;
    int                            fill;
    logic                          zoom_on;
    logic [MS_W-1:0]               hold_left;

    cursor_report_t due_reports [$];

    function automatic cursor_report_t apply_item(
        input logic                          op,
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py
    );
        cursor_report_t rep;
        longint         ax, ay, thr;
        int             dx, dy, dir, last_dir, slot, a, b, k;
        rep = '0;
        if (op == OP_TICK) begin
            ms_clock = ms_clock + 1'b1;
            if (zoom_on && hold_left != '0) begin
                hold_left = hold_left - 1'b1;
                if (hold_left == '0) begin
                    zoom_on = 1'b0;
                    rep.size_changed = 1'b1;
                end
            end
        end else begin
            // full ring: drop the oldest before storing
            if (fill >= HISTORY_DEPTH) begin
                oldest = (oldest + 1) % HISTORY_DEPTH;
                fill--;
            end
            slot = (oldest + fill) % HISTORY_DEPTH;
            hist_x[slot] = px;
            hist_y[slot] = py;
            hist_t[slot] = ms_clock;
            fill++;
            // age is a modulo difference; the newest sample is age 0
            while (fill > 0 && TIME_W'(ms_clock - hist_t[oldest]) > TIME_W'(window_ms)) begin
                oldest = (oldest + 1) % HISTORY_DEPTH;
                fill--;
            end
            if (fill >= int'(min_samples)) begin
                last_dir = 0;
                thr = step_thr;
                for (k = 1; k < fill; k++) begin
                    a = (oldest + k - 1) % HISTORY_DEPTH;
                    b = (oldest + k) % HISTORY_DEPTH;
                    dx = int'(hist_x[b]) - int'(hist_x[a]);
                    dy = int'(hist_y[b]) - int'(hist_y[a]);
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    if (ax > thr || ay > thr || ax * ax + ay * ay > thr * thr) begin
                        dir = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
                        if (dir * last_dir < 0 && rep.reversals != REV_MAX)
                            rep.reversals = rep.reversals + 1'b1;
                        last_dir = dir;
                    end
                end
                rep.shake_detected = (rep.reversals >= min_reversals);
            end
            // a shake while already zoomed leaves the countdown alone
            if (rep.shake_detected && !zoom_on) begin
                zoom_on = 1'b1;
                hold_left = (hold_ms != '0) ? hold_ms : MS_W'(1);
                rep.size_changed = 1'b1;
            end
        end
        rep.zoomed = zoom_on;
        rep.cursor_size = zoom_on ? large_size : normal_size;
        return rep;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        cursor_report_t got, want;
        if (!aresetn) begin
            window_ms     = WINDOW_RST;
            step_thr      = THRESHOLD_RST;
            min_reversals = MIN_REV_RST;
            min_samples   = MIN_SAMPLES_RST;
            hold_ms       = HOLD_RST;
            normal_size   = NORMAL_RST;
            large_size    = LARGE_RST;
            ms_clock      = '0;
            oldest        = 0;
            fill          = 0;
            zoom_on       = 1'b0;
            hold_left     = '0;
            mismatches    = 0;
            due_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_zoomed, m_cursor_size, m_size_changed, m_shake_detected,
                       m_reversals};
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, got);
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("zoomed", want.zoomed, got.zoomed);
                    check_field("cursor_size", want.cursor_size, got.cursor_size);
                    check_field("size_changed", want.size_changed, got.size_changed);
                    check_field("shake_detected", want.shake_detected, got.shake_detected);
                    check_field("reversals", want.reversals, got.reversals);
                end
            end
            if (s_valid && s_ready)
                due_reports.push_back(apply_item(s_opcode, s_pos_x, s_pos_y));
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WINDOW_MS:      window_ms     = cfg_data[MS_W-1:0];
                    CFG_STEP_THRESHOLD: step_thr      = cfg_data[THR_W-1:0];
                    CFG_MIN_REVERSALS:  min_reversals = cfg_data[REV_W-1:0];
                    CFG_MIN_SAMPLES:    min_samples   = cfg_data[MINS_W-1:0];
                    CFG_HOLD_MS:        hold_ms       = cfg_data[MS_W-1:0];
                    CFG_NORMAL_SIZE:    normal_size   = cfg_data[SIZE_W-1:0];
                    CFG_LARGE_SIZE:     large_size    = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding <= due_reports.size();
    end

endmodule

// File: tb/sv/cursor_shake_detector_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_shake_detector_top_tb
// Drives ticks, shake bursts and random moves into the shake detector under
// a series of register settings, with random stalls on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module cursor_shake_detector_top_tb;
    import csd_pkg::*;

    localparam int DEPTH   = 64;
    localparam int COORD_W = 16;
    localparam int PHASES  = 8;
    localparam int PHASE_ITEMS = 200;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct {
        int unsigned window;
        int unsigned thr;
        int unsigned min_rev;
        int unsigned min_samp;
        int unsigned hold;
        int unsigned normal;
        int unsigned enlarged;
    } shake_cfg_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_opcode;
    logic signed [COORD_W-1:0] s_pos_x;
    logic signed [COORD_W-1:0] s_pos_y;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_zoomed;
    logic [SIZE_W-1:0]         m_cursor_size;
    logic                      m_size_changed;
    logic                      m_shake_detected;
    logic [REV_W-1:0]          m_reversals;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    int                        mismatches;
    int                        outstanding;

    shake_cfg_t cur;
    int         items_sent;
    int         send_calm;

    cursor_shake_detector_top #(
        .HISTORY_DEPTH(DEPTH),
        .COORD_WIDTH  (COORD_W)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_zoomed        (m_zoomed),
        .m_cursor_size   (m_cursor_size),
        .m_size_changed  (m_size_changed),
        .m_shake_detected(m_shake_detected),
        .m_reversals     (m_reversals),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    cursor_shake_checker #(
        .HISTORY_DEPTH(DEPTH),
        .COORD_WIDTH  (COORD_W)
    ) size_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_zoomed        (m_zoomed),
        .m_cursor_size   (m_cursor_size),
        .m_size_changed  (m_size_changed),
        .m_shake_detected(m_shake_detected),
        .m_reversals     (m_reversals),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic op, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        gap = 0;
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 99) < 4)
            send_calm = $urandom_range(20, 100);
        else if ($urandom_range(0, 99) < 30)
            gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_pos_x  <= x;
        s_pos_y  <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // wait for every result, then idle before returning
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // cfg_we stays high across back-to-back writes; caller lowers it
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << width) - 1);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        // junk above the register width now and then
        if ($urandom_range(0, 1) != 0)
            cfg_data <= (CFG_DATA_W'(value) & keep) | (CFG_DATA_W'($urandom) & ~keep);
        else
            cfg_data <= CFG_DATA_W'(value) & keep;
        @(posedge aclk);
    endtask

    // receiver: random stalls, calm stretches, one long hold-off
    initial begin : receiver
        int  taken, stall_left, calm_left, r;
        bit  pressure_done;
        taken = 0;
        stall_left = 0;
        calm_left = 0;
        pressure_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                taken++;
            if (stall_left > 0) begin
                stall_left--;
            end else if (!pressure_done && taken >= 250) begin
                stall_left = 400;
                pressure_done = 1;
            end else if (calm_left > 0) begin
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(50, 200);
                else if (r < 25)
                    stall_left = gap_len();
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin : stimulus
        int p, start, n, amp, jit, i, cap, bx, by, kind, side;
        s_valid   <= 1'b0;
        s_opcode  <= OP_TICK;
        s_pos_x   <= '0;
        s_pos_y   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_WINDOW_MS;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        items_sent = 0;
        send_calm = 0;
        cur = '{500, 10, 4, 5, 2000, 24, 64};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, a shake at reset settings, threshold edges
        send_tick();
        send_item(OP_MOVE, 16'sh8000, 16'sh7fff);
        send_item(OP_MOVE, 16'sh7fff, 16'sh8000);
        send_item(OP_MOVE, -16'sd1, 16'sd0);
        send_item(OP_MOVE, 16'sd0, -16'sd1);
        for (i = 0; i < 6; i++)
            send_item(OP_MOVE, (i % 2) ? 16'sd100 : 16'sd0, 16'sd0);
        send_item(OP_MOVE, 16'sd0, 16'sd0);      // shake while zoomed
        send_item(OP_MOVE, 16'sd110, 16'sd0);    // x step far over threshold
        send_item(OP_MOVE, 16'sd116, 16'sd8);    // length exactly threshold
        send_item(OP_MOVE, 16'sd123, 16'sd16);   // just over
        send_item(OP_MOVE, 16'sd123, 16'sd500);  // vertical only, no x sign
        send_tick();
        send_tick();

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: cur = '{0, 0, 0, 0, 0, 1, 255};
                    2: cur = '{1, 1, 1, 1, 1, 255, 0};
                    3: cur = '{65535, 4095, 63, 64, 65535, 255, 255};
                    4: cur = '{65535, 5, 8, 64, 30, $urandom_range(0, 255),
                               $urandom_range(0, 255)};
                    default: begin
                        i = $urandom_range(0, 9);
                        cur.window = (i < 7) ? $urandom_range(2, 60) :
                                     (i < 9) ? $urandom_range(60, 600) : $urandom_range(0, 1);
                        i = $urandom_range(0, 9);
                        cur.thr = (i < 6) ? $urandom_range(0, 40) :
                                  (i < 9) ? $urandom_range(40, 400) : $urandom_range(400, 4095);
                        cur.min_rev = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8) :
                                      $urandom_range(0, 63);
                        i = $urandom_range(0, 9);
                        cur.min_samp = (i < 8) ? $urandom_range(0, 10) :
                                       (i < 9) ? $urandom_range(10, 64) : $urandom_range(64, 127);
                        cur.hold = $urandom_range(0, 40);
                        cur.normal = $urandom_range(0, 255);
                        cur.enlarged = $urandom_range(0, 255);
                    end
                endcase
                put_reg(CFG_SPARE_IDX, $urandom, CFG_DATA_W);
                put_reg(CFG_WINDOW_MS, cur.window, MS_W);
                put_reg(CFG_STEP_THRESHOLD, cur.thr, THR_W);
                put_reg(CFG_MIN_REVERSALS, cur.min_rev, REV_W);
                put_reg(CFG_MIN_SAMPLES, cur.min_samp, MINS_W);
                put_reg(CFG_HOLD_MS, cur.hold, MS_W);
                put_reg(CFG_NORMAL_SIZE, cur.normal, SIZE_W);
                put_reg(CFG_LARGE_SIZE, cur.enlarged, SIZE_W);
                cfg_we <= 1'b0;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    // shake burst: x swings by amp, mostly over the threshold
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) :
                        $urandom_range(3, 12);
                    amp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cur.thr) :
                          cur.thr + $urandom_range(1, 60);
                    bx = $urandom_range(0, 65535) - 32768;
                    by = $urandom_range(0, 65535) - 32768;
                    jit = $urandom_range(0, 8);
                    side = 0;
                    for (i = 0; i < n; i++) begin
                        if ($urandom_range(0, 9) != 0)
                            side = 1 - side;
                        send_item(OP_MOVE, COORD_W'(bx + side * amp),
                                  COORD_W'(by + $urandom_range(0, 2 * jit) - jit));
                        if ($urandom_range(0, 3) == 0)
                            repeat ($urandom_range(1, 2)) send_tick();
                    end
                end else if (kind < 80) begin
                    // tick run, long enough now and then to expire hold and window
                    cap = cur.hold + cur.window + 4;
                    if (cap > 300)
                        cap = 300;
                    n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) :
                        $urandom_range(1, cap);
                    repeat (n) send_tick();
                end else begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 2) == 0)
                            send_tick();
                        else
                            send_item(OP_MOVE, COORD_W'($urandom), COORD_W'($urandom));
                    end
                end
            end
        end

        settle();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS cursor_shake_detector_top");
        end else begin
            $display("FAIL cursor_shake_detector_top");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAIL cursor_shake_detector_top");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/csd_pkg.sv
hw/rtl/csd_ram.sv
hw/rtl/csd_step_unit.sv
hw/rtl/cursor_shake_detector_top.sv
tb/sv/cursor_shake_checker.sv
tb/sv/cursor_shake_detector_top_tb.sv
